/* rtl/lsvm_pkg.sv */
package lsvm_pkg;

  localparam int WORD_W = 16;
  localparam int EXP_W  = 4;
  localparam int MANT_W = 12;
  localparam int VAL_W  = 27;
  localparam int REG_W  = 27;
  localparam int IDX_W  = 2;

  localparam logic [WORD_W-1:0] FAIL_WORD = 16'hFFFF;
  localparam logic [VAL_W-1:0]  MAX_VALUE = 27'd134184960;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_MIN   = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX   = 2'd1;
  localparam logic [IDX_W-1:0] REG_JUMP  = 2'd2;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_COMM   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_JUMP   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load_word;
    logic decode;
    logic check;
    logic commit;
    logic scan_clear;
    logic scan_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    status_t err;
    logic    found;
  } sts_t;

endpackage

/* rtl/lsvm_ctrl.sv */
module lsvm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lsvm_pkg::sts_t    sts,
  output lsvm_pkg::cmd_t    cmd
);

  lsvm_pkg::state_t state;
  lsvm_pkg::state_t state_next;
  logic             out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lsvm_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lsvm_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = lsvm_pkg::S_DECODE;
        end
      end
      lsvm_pkg::S_DECODE: begin
        state_next = lsvm_pkg::S_CHECK;
      end
      lsvm_pkg::S_CHECK: begin
        if (sts.err == lsvm_pkg::ST_NORMAL) begin
          state_next = lsvm_pkg::S_SCAN;
        end else begin
          state_next = lsvm_pkg::S_FINISH;
        end
      end
      lsvm_pkg::S_SCAN: begin
        if (sts.found) begin
          state_next = lsvm_pkg::S_FINISH;
        end
      end
      lsvm_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = lsvm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lsvm_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      lsvm_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_word = in_valid;
      end
      lsvm_pkg::S_DECODE: begin
        cmd.decode = 1'b1;
      end
      lsvm_pkg::S_CHECK: begin
        cmd.check      = 1'b1;
        cmd.commit     = (sts.err == lsvm_pkg::ST_NORMAL);
        cmd.scan_clear = 1'b1;
      end
      lsvm_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      lsvm_pkg::S_FINISH: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* rtl/lsvm_dp.sv */
module lsvm_dp #(
  parameter int WINDOW_DEPTH = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lsvm_pkg::IDX_W-1:0]   cfg_index,
  input  logic [lsvm_pkg::REG_W-1:0]   cfg_data,
  input  logic [lsvm_pkg::WORD_W-1:0]  result_word,
  input  lsvm_pkg::cmd_t               cmd,
  output lsvm_pkg::sts_t               sts,
  output logic [lsvm_pkg::VAL_W-1:0]   light_centilux,
  output lsvm_pkg::status_t            status
);

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
  localparam logic [CNT_W-1:0]  MID       = CNT_W'(WINDOW_DEPTH / 2);

  logic [lsvm_pkg::REG_W-1:0]  min_centilux;
  logic [lsvm_pkg::REG_W-1:0]  max_centilux;
  logic [lsvm_pkg::REG_W-1:0]  jump_limit_centilux;

  logic [lsvm_pkg::VAL_W-1:0]  window [WINDOW_DEPTH];
  logic [SLOT_W-1:0]           write_slot;
  logic [lsvm_pkg::VAL_W-1:0]  last_good_value;

  logic [lsvm_pkg::WORD_W-1:0] word;
  logic [lsvm_pkg::VAL_W-1:0]  value;
  logic [SLOT_W-1:0]           scan_idx;
  logic [lsvm_pkg::VAL_W-1:0]  median;
  lsvm_pkg::status_t           err_code;

  logic [lsvm_pkg::MANT_W-1:0] mant;
  logic [lsvm_pkg::EXP_W-1:0]  expo;
  logic [lsvm_pkg::VAL_W-1:0]  diff;
  logic                        range_bad;
  logic                        jump_bad;
  logic [lsvm_pkg::VAL_W-1:0]  cand;
  logic [CNT_W-1:0]            n_less;
  logic [CNT_W-1:0]            n_less_eq;
  lsvm_pkg::status_t           err_now;
  logic                        found_now;

  assign mant = word[lsvm_pkg::MANT_W-1:0];
  assign expo = word[lsvm_pkg::WORD_W-1:lsvm_pkg::MANT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_centilux        <= '0;
      max_centilux        <= lsvm_pkg::MAX_VALUE;
      jump_limit_centilux <= lsvm_pkg::MAX_VALUE;
    end else if (cfg_we) begin
      case (cfg_index)
        lsvm_pkg::REG_MIN:  min_centilux        <= cfg_data;
        lsvm_pkg::REG_MAX:  max_centilux        <= cfg_data;
        lsvm_pkg::REG_JUMP: jump_limit_centilux <= cfg_data;
        default: ;
      endcase
    end
  end

  // Checks run on the word and its decoded value, in priority order.
  always_comb begin
    range_bad = (value < min_centilux) || (value > max_centilux);
    diff      = (value >= last_good_value) ? (value - last_good_value)
                                           : (last_good_value - value);
    jump_bad  = (last_good_value != '0) && (diff > jump_limit_centilux);
    if (word == lsvm_pkg::FAIL_WORD) begin
      err_now = lsvm_pkg::ST_COMM;
    end else if (range_bad) begin
      err_now = lsvm_pkg::ST_RANGE;
    end else if (jump_bad) begin
      err_now = lsvm_pkg::ST_JUMP;
    end else begin
      err_now = lsvm_pkg::ST_NORMAL;
    end
  end

  // One candidate per cycle is ranked against every window entry. It is the
  // median when fewer than MID+1 entries lie below it and more than MID lie
  // at or below it.
  assign cand = window[scan_idx];

  always_comb begin
    n_less    = '0;
    n_less_eq = '0;
    for (int j = 0; j < WINDOW_DEPTH; j++) begin
      n_less    = n_less + CNT_W'(window[j] < cand);
      n_less_eq = n_less_eq + CNT_W'(window[j] <= cand);
    end
    found_now = (n_less <= MID) && (n_less_eq > MID);
  end

  assign sts = '{err: err_now, found: found_now};

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      word <= result_word;
    end
    if (cmd.decode) begin
      value <= lsvm_pkg::VAL_W'(mant) << expo;
    end
    if (cmd.check) begin
      err_code <= sts.err;
    end
    if (cmd.scan_clear) begin
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (cmd.scan_step && sts.found) begin
      median <= cand;
    end
    if (cmd.load_out) begin
      status <= err_code;
      if (err_code == lsvm_pkg::ST_NORMAL) begin
        light_centilux <= median;
      end else begin
        light_centilux <= last_good_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        window[i] <= '0;
      end
      write_slot      <= '0;
      last_good_value <= '0;
    end else begin
      if (cmd.commit) begin
        window[write_slot] <= value;
        write_slot         <= (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
      end
      if (cmd.load_out && err_code == lsvm_pkg::ST_NORMAL) begin
        last_good_value <= median;
      end
    end
  end

endmodule

/* rtl/lux_sample_validate_median_top.sv */
// A rejected or failed read passes from the input transfer through decode and the checks
// to the output register; an accepted value also passes the median search, which ranks
// one window entry per cycle until it finds the middle one.
// A new item is taken only once the result of the last one is in the output register.
// Reset (synchronous, active high) clears the window, write slot and last good value to
// zero and loads the range and jump registers with their defaults.
module lux_sample_validate_median_top #(
  parameter int WINDOW_DEPTH = 5
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: 0 min_centilux, 1 max_centilux, 2 jump_limit_centilux.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [26:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] result_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [26:0] light_centilux, [31:27] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  lsvm_pkg::cmd_t                cmd;
  lsvm_pkg::sts_t                sts;
  logic [lsvm_pkg::VAL_W-1:0]    light_centilux;
  lsvm_pkg::status_t             status;

  // The controller steps each item through decode, checking, the median
  // search and the output register. The output register is a stage of its
  // own, so a new input transfer can be taken while a result still waits.
  lsvm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the configuration registers, the ring window and the
  // last good value, and ranks window entries for the median.
  lsvm_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .result_word    (s_tdata),
    .cmd            (cmd),
    .sts            (sts),
    .light_centilux (light_centilux),
    .status         (status)
  );

  assign m_tdata = {5'b0, light_centilux};
  assign m_tuser = status;

endmodule

/* rtl/lsvm_chk.sv */
module lsvm_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // A held result keeps its value until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // The filtered value never exceeds the largest decodable reading.
  a_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata <= 32'(lsvm_pkg::MAX_VALUE))
    else $error("light value above decodable range");

  // One item is worked on at a time, so an input transfer closes the input.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind lux_sample_validate_median_top lsvm_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

// Self-checking bench for the light-sensor validation and median block.
// A directed plan walks the corner cases first: failed reads, the all-zero
// window, the largest exponent, inclusive range bounds, an empty range,
// the jump limit hit exactly and overshot by one, and the median falling
// back to zero. Random phases follow, each with its own register setting.
// Every accepted input word is run through a local model of the filter.
// The outcome is queued and compared with each output transfer in turn.
module tb_top;

  localparam int WINDOW_DEPTH  = 5;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 113;
  localparam int IDLE_PCT      = 32;
  // A rejected word skips the median search and an accepted one runs it;
  // this pause covers the block's own work on either with a good margin.
  localparam int SETTLE_CYCLES = WINDOW_DEPTH + 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam int SHOWN_FAULTS  = 10;

  // Register index that no register uses; it marks plan rows that are sensor words.
  localparam logic [lsvm_pkg::IDX_W-1:0] NO_REG = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // One row of the directed plan. A sensor word travels in the low 16 bits of arg.
  // Where hand is set, light and status are the outcome worked out by hand.
  // That outcome replaces the model's at the comparison, and the model still steps.
  typedef struct packed {
    row_kind_t                  kind;
    logic [lsvm_pkg::IDX_W-1:0] idx;
    logic [lsvm_pkg::REG_W-1:0] arg;
    logic                       hand;
    logic [lsvm_pkg::VAL_W-1:0] light;
    lsvm_pkg::status_t          status;
  } plan_row_t;

  typedef struct packed {
    logic [lsvm_pkg::VAL_W-1:0] light;
    lsvm_pkg::status_t          status;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = lsvm_pkg::REG_MIN;
  logic [26:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  always #1 clk = ~clk;

  lux_sample_validate_median_top #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  // Local copy of the filter state and its three registers, as after reset.
  logic [27:0]                win_entry [WINDOW_DEPTH] = '{default: '0};
  int unsigned                next_slot = 0;
  logic [27:0]                held_value = '0;
  logic [lsvm_pkg::REG_W-1:0] lo_bound = '0;
  logic [lsvm_pkg::REG_W-1:0] hi_bound = lsvm_pkg::MAX_VALUE;
  logic [lsvm_pkg::REG_W-1:0] step_limit = lsvm_pkg::MAX_VALUE;

  reading_t  expected_q [$];
  plan_row_t offered_q [$];
  int        mismatches = 0;
  int        quiet_cycles = 0;
  bit        calm = 1'b0;
  bit        squeeze_req = 1'b0;
  int        hold_left = 0;
  reading_t  outcome;
  plan_row_t offered;

  // The first rows run from reset with the default registers.
  // The all-zero window keeps the median at zero until real values outnumber
  // the zero entries. After row 5 the last good value is 4095.
  // After row 17 it is 3995 and stays there until the zeros come back.
  plan_row_t directed_plan [30] = '{
    '{ROW_ITEM, NO_REG, 27'(lsvm_pkg::FAIL_WORD), 1'b1, 27'd0, lsvm_pkg::ST_COMM},
    '{ROW_ITEM, NO_REG, 27'h00000, 1'b1, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_ITEM, NO_REG, 27'h0FFFE, 1'b1, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_ITEM, NO_REG, 27'h0EFFF, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_ITEM, NO_REG, 27'h00FFF, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_ITEM, NO_REG, 27'h01000, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    // Range 100 to 5000: one below, both bounds, and one step above.
    '{ROW_REG, lsvm_pkg::REG_MIN, 27'd100, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_REG, lsvm_pkg::REG_MAX, 27'd5000, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_ITEM, NO_REG, 27'h00063, 1'b1, 27'd4095, lsvm_pkg::ST_RANGE},
    '{ROW_ITEM, NO_REG, 27'h00064, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_ITEM, NO_REG, 27'h019C4, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_ITEM, NO_REG, 27'h019C5, 1'b1, 27'd4095, lsvm_pkg::ST_RANGE},
    // Lower bound above the upper one: nothing can pass.
    '{ROW_REG, lsvm_pkg::REG_MIN, 27'd6000, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_ITEM, NO_REG, 27'h00FA0, 1'b1, 27'd4095, lsvm_pkg::ST_RANGE},
    // Jump limit 100: exactly 100 passes and 101 does not.
    '{ROW_REG, lsvm_pkg::REG_MIN, 27'd0, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_REG, lsvm_pkg::REG_MAX, lsvm_pkg::MAX_VALUE, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_REG, lsvm_pkg::REG_JUMP, 27'd100, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_ITEM, NO_REG, 27'h00F9B, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_ITEM, NO_REG, 27'h00F36, 1'b1, 27'd3995, lsvm_pkg::ST_JUMP},
    '{ROW_ITEM, NO_REG, 27'h00FFF, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    // A zero limit admits only the last good value itself.
    '{ROW_REG, lsvm_pkg::REG_JUMP, 27'd0, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_ITEM, NO_REG, 27'h00F9B, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_ITEM, NO_REG, 27'h00F9C, 1'b1, 27'd3995, lsvm_pkg::ST_JUMP},
    // Zeros under three exponents pull the median back to zero.
    // After that a large value passes even with a zero limit.
    '{ROW_REG, lsvm_pkg::REG_JUMP, lsvm_pkg::MAX_VALUE, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_ITEM, NO_REG, 27'h00000, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_ITEM, NO_REG, 27'h02000, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_ITEM, NO_REG, 27'h0F000, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_REG, lsvm_pkg::REG_JUMP, 27'd0, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_ITEM, NO_REG, 27'h0EFFF, 1'b0, 27'd0, lsvm_pkg::ST_NORMAL},
    '{ROW_ITEM, NO_REG, 27'(lsvm_pkg::FAIL_WORD), 1'b0, 27'd0, lsvm_pkg::ST_NORMAL}
  };

  // Steps the local filter by one sensor word and returns its outcome.
  // The checks run in order: failed read, then range, then jump.
  // Only a value that passes all three enters the window.
  function automatic reading_t filter_reading(input logic [15:0] word);
    logic [31:0] lux;
    logic [31:0] gap;
    logic [27:0] sorted [WINDOW_DEPTH];
    logic [27:0] key;
    int          j;
    reading_t    r;
    r.light  = held_value[lsvm_pkg::VAL_W-1:0];
    r.status = lsvm_pkg::ST_NORMAL;
    if (word == lsvm_pkg::FAIL_WORD) begin
      r.status = lsvm_pkg::ST_COMM;
    end else begin
      lux = 32'(word[lsvm_pkg::MANT_W-1:0]) << word[lsvm_pkg::WORD_W-1:lsvm_pkg::MANT_W];
      if (lux < 32'(lo_bound) || lux > 32'(hi_bound)) begin
        r.status = lsvm_pkg::ST_RANGE;
      end else begin
        gap = (lux >= 32'(held_value)) ? lux - 32'(held_value) : 32'(held_value) - lux;
        if (held_value != '0 && gap > 32'(step_limit)) begin
          r.status = lsvm_pkg::ST_JUMP;
        end else begin
          if (next_slot >= WINDOW_DEPTH) next_slot = 0;
          win_entry[next_slot] = lux[27:0];
          next_slot = (next_slot + 1) % WINDOW_DEPTH;
          sorted = win_entry;
          for (int i = 1; i < WINDOW_DEPTH; i++) begin
            key = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > key) begin
              sorted[j + 1] = sorted[j];
              j--;
            end
            sorted[j + 1] = key;
          end
          held_value = sorted[WINDOW_DEPTH / 2];
          r.light    = held_value[lsvm_pkg::VAL_W-1:0];
        end
      end
    end
    return r;
  endfunction

  // Draws a register value. Each register has its own menu of values, and every
  // menu contains the extremes.
  function automatic logic [lsvm_pkg::REG_W-1:0] pick_setting(
    input logic [lsvm_pkg::IDX_W-1:0] idx
  );
    int unsigned roll;
    logic [lsvm_pkg::REG_W-1:0] v;
    roll = $urandom_range(9);
    case (idx)
      lsvm_pkg::REG_MIN: begin
        if (roll < 5)      v = '0;
        else if (roll < 8) v = lsvm_pkg::REG_W'($urandom_range(3000));
        else if (roll < 9) v = lsvm_pkg::REG_W'($urandom_range(200000));
        else               v = lsvm_pkg::MAX_VALUE;
      end
      lsvm_pkg::REG_MAX: begin
        if (roll < 5)      v = lsvm_pkg::MAX_VALUE;
        else if (roll < 6) v = '1;
        else if (roll < 9) v = lsvm_pkg::REG_W'($urandom_range(60000, 2000));
        else               v = lsvm_pkg::REG_W'($urandom_range(1000));
      end
      default: begin
        if (roll < 4)      v = lsvm_pkg::REG_W'($urandom_range(20000, 500));
        else if (roll < 6) v = lsvm_pkg::MAX_VALUE;
        else if (roll < 7) v = '1;
        else if (roll < 8) v = '0;
        else               v = lsvm_pkg::REG_W'($urandom_range(2000, 50));
      end
    endcase
    return v;
  endfunction

  // Most random words carry small values or values near the last good value,
  // so that they pass the checks and move the median. The rest are failed reads
  // and words with every bit random.
  function automatic logic [15:0] pick_word();
    int unsigned roll;
    int unsigned span;
    int unsigned e;
    logic [31:0] aim;
    logic [15:0] w;
    roll = $urandom_range(99);
    if (roll < 4) begin
      w = lsvm_pkg::FAIL_WORD;
    end else if (roll < 22) begin
      w = 16'($urandom);
    end else if (roll < 55) begin
      w = {4'($urandom_range(2)), 12'($urandom)};
    end else begin
      span = (step_limit < 27'd4000) ? int'(step_limit) + 1 : 4000;
      aim  = 32'(held_value);
      if ($urandom_range(1) == 0 || aim < span) aim = aim + $urandom_range(span);
      else aim = aim - $urandom_range(span);
      e = 0;
      while ((aim >> e) > 4095 && e < 15) e++;
      w = {4'(e), 12'(aim >> e)};
    end
    return w;
  endfunction

  task automatic note_fault(input string msg);
    mismatches++;
    if (mismatches <= SHOWN_FAULTS) $display("%s", msg);
  endtask

  // Register writes happen only while the block is idle. The model's copy is
  // updated at the same edge. The task then lowers the write enable and waits,
  // so that the write enable is never lowered and raised in one time step.
  task automatic write_reg(input logic [lsvm_pkg::IDX_W-1:0] idx,
                           input logic [lsvm_pkg::REG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      lsvm_pkg::REG_MIN:  lo_bound   = val;
      lsvm_pkg::REG_MAX:  hi_bound   = val;
      lsvm_pkg::REG_JUMP: step_limit = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drops valid and waits until every queued outcome has been matched.
  // The first edge lets the monitor record a transfer made at this very edge.
  // The settle pause then lets the block finish anything still in its pipeline.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offers one word after an optional random gap. It returns at the edge where
  // the transfer is made, with valid still high. The row goes into a queue, so
  // the monitor knows whether a hand-worked outcome applies.
  task automatic send_item(input logic [15:0] word, input plan_row_t row);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    offered_q.push_back(row);
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stimulus: reset, the directed plan, then the random phases.
  // Phase 0 opens every register as wide as it goes.
  // Phase 2 starts with a long receiver hold-off. Phase 4 runs with no idling
  // on either side.
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_plan[n]) begin
      if (directed_plan[n].kind == ROW_REG) begin
        wait_idle();
        write_reg(directed_plan[n].idx, directed_plan[n].arg);
      end else begin
        send_item(directed_plan[n].arg[15:0], directed_plan[n]);
      end
    end
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      if (phase == 0) begin
        write_reg(lsvm_pkg::REG_MIN, '0);
        write_reg(lsvm_pkg::REG_MAX, '1);
        write_reg(lsvm_pkg::REG_JUMP, '1);
      end else begin
        write_reg(lsvm_pkg::REG_MIN, pick_setting(lsvm_pkg::REG_MIN));
        write_reg(lsvm_pkg::REG_MAX, pick_setting(lsvm_pkg::REG_MAX));
        write_reg(lsvm_pkg::REG_JUMP, pick_setting(lsvm_pkg::REG_JUMP));
      end
      calm = (phase == 4);
      if (phase == 2) squeeze_req = 1'b1;
      repeat (PHASE_ITEMS) send_item(pick_word(), '0);
    end
    wait_idle();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("lux_sample_validate_median_top test passed");
    end else begin
      $display("lux_sample_validate_median_top test failed");
    end
    $finish;
  end

  // Receiver: stalls at random, except in the calm phase. When asked, it holds
  // ready low for a long count, so that the block fills up and pushes back on
  // its input.
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Monitor: samples both buses at each rising edge. It predicts on input
  // transfers and compares on output transfers. It also counts the cycles in
  // which nothing moves.
  always @(posedge clk) begin
    if (!rst) begin
      quiet_cycles++;
      if (cfg_we) quiet_cycles = 0;
      if (s_tvalid && s_tready) begin
        quiet_cycles = 0;
        offered = offered_q.pop_front();
        outcome = filter_reading(s_tdata);
        if (offered.hand) begin
          outcome.light  = offered.light;
          outcome.status = offered.status;
        end
        expected_q.push_back(outcome);
      end
      if (m_tvalid && m_tready) begin
        quiet_cycles = 0;
        if (expected_q.size() == 0) begin
          note_fault($sformatf("unexpected transfer: light %0d status %0d",
                               m_tdata, m_tuser));
        end else begin
          outcome = expected_q.pop_front();
          if (m_tdata !== {5'd0, outcome.light} || m_tuser !== outcome.status) begin
            note_fault($sformatf(
              "mismatch: got light %0d status %0d, expected light %0d status %0d",
              m_tdata, m_tuser, outcome.light, outcome.status));
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("lux_sample_validate_median_top test failed");
        $finish;
      end
    end
  end

endmodule
